@@ rtl/dcs_pkg.sv @@
// shared constants, types and cosine table builder for the day cycle sky color unit
package dcs_pkg;

    localparam int PHASE_BITS      = 16;
    localparam int COS_TABLE_DEPTH = 1024;

    localparam int OFS_W   = PHASE_BITS - 2;
    localparam int ADDR_W  = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PROD_W  = OFS_W + ADDR_W;

    localparam int SUN_W   = 16;
    localparam int COLOR_W = 12;
    localparam int LIGHT_W = 13;
    localparam int COS_W   = 15;
    localparam int DIST_W  = 17;
    localparam int WGT_W   = 16;
    localparam int T_W     = 15;
    localparam int RECIP_W = 18;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WGT_W-1:0]   ONE14       = 16'd16384;
    localparam logic [LIGHT_W-1:0] ONE12       = 13'd4096;
    localparam logic [LIGHT_W-1:0] FLOOR_RESET = 13'd901;
    localparam logic [COLOR_W-1:0] COLOR_MAX   = 12'd4095;

    localparam logic signed [DIST_W-1:0] DAY_EDGE   = 17'sd819;
    localparam logic signed [DIST_W-1:0] LIGHT_EDGE = 17'sd2458;
    localparam logic [RECIP_W-1:0] RECIP_DAY   = 18'd218453;
    localparam logic [RECIP_W-1:0] RECIP_LIGHT = 18'd145636;

    // palettes, Q0.12, channel order red green blue
    localparam logic [COLOR_W-1:0] PAL_DAY_Z [3] = '{12'd1434, 12'd2253, 12'd3686};
    localparam logic [COLOR_W-1:0] PAL_DAY_H [3] = '{12'd2867, 12'd3359, 12'd3891};
    localparam logic [COLOR_W-1:0] PAL_TW_Z  [3] = '{12'd983,  12'd1147, 12'd2130};
    localparam logic [COLOR_W-1:0] PAL_TW_H  [3] = '{12'd3891, 12'd2130, 12'd983};
    localparam logic [COLOR_W-1:0] PAL_NGT_Z [3] = '{12'd82,   12'd123,  12'd369};
    localparam logic [COLOR_W-1:0] PAL_NGT_H [3] = '{12'd246,  12'd328,  12'd696};

    localparam int COS_TERMS = 10;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    // (2k-1)*(2k) for the taylor terms
    localparam logic [63:0] COS_DIV [COS_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

    typedef struct packed {
        logic              sun_neg;
        logic [ADDR_W-1:0] addr;
    } dcs_item_t;

    typedef logic [COS_W-1:0] cos_rom_t [COS_TABLE_DEPTH + 1];

    // one table entry, cos(pi/2*i/depth) in Q1.14 via a Q30 series
    function automatic logic [COS_W-1:0] cos_q14(int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] c;
        logic [63:0] r;
        x    = (HALF_PI_Q30 * 64'(i)) / COS_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        pos  = term;
        neg  = 64'd0;
        for (int k = 1; k <= COS_TERMS; k++) begin
            term = ((term * x2) >> 30) / COS_DIV[k-1];
            if ((k % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        c = (pos > neg) ? pos - neg : 64'd0;
        r = (c + (64'd1 << 15)) >> 16;
        if (r > 64'(ONE14)) begin
            r = 64'(ONE14);
        end
        return r[COS_W-1:0];
    endfunction

    function automatic cos_rom_t cos_rom_build();
        cos_rom_t rom;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
            rom[i] = cos_q14(i);
        end
        return rom;
    endfunction

    // ramp position of a smoothstep, clamped to one
    function automatic logic [T_W-1:0] ramp_t(logic signed [DIST_W-1:0] d,
                                              logic [RECIP_W-1:0] recip);
        logic [34:0] prod;
        logic [18:0] t;
        if (d <= 0) begin
            return '0;
        end
        prod = 35'(d[15:0]) * 35'(recip) + 35'(32768);
        t    = prod[34:16];
        if (t > 19'(ONE14)) begin
            return T_W'(ONE14);
        end
        return t[T_W-1:0];
    endfunction

endpackage

@@ rtl/day_cycle_sky_color_unit.sv @@
// top level of the day cycle sky color unit
// path from input transfer to earliest result transfer: front register, queue, 8 math stages
// throughput: one phase per cycle unless a result waits; every stage and the cosine rom read take one a cycle
// while a result waits for m_ready the math pipeline holds; queue and front register take up to five more phases
// reset clears the front, queue and pipeline valid state and sets the night floor to 901
// the cosine rom is constant, so no clearing pass follows reset
module day_cycle_sky_color_unit import dcs_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [LIGHT_W-1:0]      cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PHASE_BITS-1:0]   s_day_phase,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUN_W-1:0] m_sun_height,
    output logic [COLOR_W-1:0]      m_zenith_red,
    output logic [COLOR_W-1:0]      m_zenith_green,
    output logic [COLOR_W-1:0]      m_zenith_blue,
    output logic [COLOR_W-1:0]      m_horizon_red,
    output logic [COLOR_W-1:0]      m_horizon_green,
    output logic [COLOR_W-1:0]      m_horizon_blue,
    output logic [LIGHT_W-1:0]      m_light_level
);

    logic      fr_valid;
    logic      fr_ready;
    dcs_item_t fr_item;
    logic      bk_valid;
    logic      bk_ready;
    dcs_item_t bk_item;

    dcs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_day_phase (s_day_phase),
        .item_valid  (fr_valid),
        .item_ready  (fr_ready),
        .item        (fr_item)
    );

    dcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_item  (bk_item)
    );

    dcs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .item_valid      (bk_valid),
        .item_ready      (bk_ready),
        .item            (bk_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sun_height    (m_sun_height),
        .m_zenith_red    (m_zenith_red),
        .m_zenith_green  (m_zenith_green),
        .m_zenith_blue   (m_zenith_blue),
        .m_horizon_red   (m_horizon_red),
        .m_horizon_green (m_horizon_green),
        .m_horizon_blue  (m_horizon_blue),
        .m_light_level   (m_light_level)
    );

endmodule

@@ rtl/dcs_front.sv @@
// front end: takes a phase transfer and turns it into a table address and sign
module dcs_front import dcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PHASE_BITS-1:0] s_day_phase,
    output logic                  item_valid,
    input  logic                  item_ready,
    output dcs_item_t             item
);

    logic            valid_reg;
    dcs_item_t       item_reg;
    dcs_item_t       item_next;
    logic [1:0]      quad;
    logic [OFS_W-1:0] ofs;
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] idx;

    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        quad = s_day_phase[PHASE_BITS-1:PHASE_BITS-2];
        ofs  = s_day_phase[OFS_W-1:0];
        prod = PROD_W'(ofs) * PROD_W'(COS_TABLE_DEPTH);
        idx  = prod[PROD_W-1:OFS_W];
        if (idx > ADDR_W'(COS_TABLE_DEPTH)) begin
            idx = ADDR_W'(COS_TABLE_DEPTH);
        end
        // odd quadrants read the table mirrored
        item_next.addr    = quad[0] ? ADDR_W'(COS_TABLE_DEPTH) - idx : idx;
        // sun is minus the table value in the first and last quadrant
        item_next.sun_neg = !(quad[1] ^ quad[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/dcs_queue.sv @@
// small fifo between the front end and the math pipeline
module dcs_queue import dcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  dcs_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output dcs_item_t out_item
);

    dcs_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/dcs_back.sv @@
// back end: cosine rom, smoothstep weights, palette mix and light level
module dcs_back import dcs_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [LIGHT_W-1:0]        cfg_wdata,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  dcs_item_t                 item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [SUN_W-1:0]   m_sun_height,
    output logic [COLOR_W-1:0]        m_zenith_red,
    output logic [COLOR_W-1:0]        m_zenith_green,
    output logic [COLOR_W-1:0]        m_zenith_blue,
    output logic [COLOR_W-1:0]        m_horizon_red,
    output logic [COLOR_W-1:0]        m_horizon_green,
    output logic [COLOR_W-1:0]        m_horizon_blue,
    output logic [LIGHT_W-1:0]        m_light_level
);

    localparam int NUM_ST = 8;
    localparam cos_rom_t COS_ROM = cos_rom_build();

    logic [NUM_ST-1:0] v_reg;
    logic              adv;
    logic [LIGHT_W-1:0] floor_reg;

    // stage 0: table read
    logic [COS_W-1:0] s0_cos_reg;
    logic             s0_neg_reg;
    // stage 1: sun height and edge distances
    logic signed [SUN_W-1:0]  s1_sun_reg;
    logic signed [DIST_W-1:0] s1_dd_reg;
    logic signed [DIST_W-1:0] s1_dn_reg;
    logic signed [DIST_W-1:0] s1_dl_reg;
    logic signed [SUN_W-1:0]  s1_sun_next;
    logic signed [DIST_W-1:0] s1_sun_ext;
    // stage 2: ramp positions
    logic signed [SUN_W-1:0] s2_sun_reg;
    logic [T_W-1:0] s2_td_reg;
    logic [T_W-1:0] s2_tn_reg;
    logic [T_W-1:0] s2_tl_reg;
    // stage 3: squares and cubic factors
    logic signed [SUN_W-1:0] s3_sun_reg;
    logic [T_W-1:0]   s3_qd_reg;
    logic [T_W-1:0]   s3_qn_reg;
    logic [T_W-1:0]   s3_ql_reg;
    logic [WGT_W-1:0] s3_kd_reg;
    logic [WGT_W-1:0] s3_kn_reg;
    logic [WGT_W-1:0] s3_kl_reg;
    logic [29:0] sq_d;
    logic [29:0] sq_n;
    logic [29:0] sq_l;
    // stage 4: weights
    logic signed [SUN_W-1:0] s4_sun_reg;
    logic [WGT_W-1:0] s4_wd_reg;
    logic [WGT_W-1:0] s4_wn_reg;
    logic [WGT_W-1:0] s4_lb_reg;
    logic [31:0] cb_d;
    logic [31:0] cb_n;
    logic [31:0] cb_l;
    // stage 5: twilight weight and floor
    logic signed [SUN_W-1:0] s5_sun_reg;
    logic [WGT_W-1:0]   s5_wd_reg;
    logic [WGT_W-1:0]   s5_wn_reg;
    logic [WGT_W-1:0]   s5_wt_reg;
    logic [WGT_W-1:0]   s5_lb_reg;
    logic [LIGHT_W-1:0] s5_fl_reg;
    logic [LIGHT_W-1:0] fl_sat;
    logic [WGT_W:0]     wsum;
    // stage 6: products
    logic signed [SUN_W-1:0] s6_sun_reg;
    logic [27:0] s6_pz_reg [3][3];
    logic [27:0] s6_ph_reg [3][3];
    logic [28:0] s6_pl_reg;
    logic [LIGHT_W-1:0] s6_fl_reg;
    // stage 7: output register
    logic signed [SUN_W-1:0] s7_sun_reg;
    logic [COLOR_W-1:0] s7_z_reg [3];
    logic [COLOR_W-1:0] s7_h_reg [3];
    logic [LIGHT_W-1:0] s7_light_reg;
    logic [COLOR_W-1:0] z_next [3];
    logic [COLOR_W-1:0] h_next [3];
    logic [29:0] zsum [3];
    logic [29:0] hsum [3];
    logic [29:0] lsum;

    // whole pipeline moves together unless the result is stuck
    assign adv        = !v_reg[NUM_ST-1] || m_ready;
    assign item_ready = adv;
    assign m_valid    = v_reg[NUM_ST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            floor_reg <= FLOOR_RESET;
        end else begin
            if (adv) begin
                v_reg <= {v_reg[NUM_ST-2:0], item_valid};
            end
            if (cfg_we) begin
                floor_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        s1_sun_next = s0_neg_reg ? -$signed({1'b0, s0_cos_reg}) : $signed({1'b0, s0_cos_reg});
        s1_sun_ext  = DIST_W'(s1_sun_next);
        sq_d = 30'(s2_td_reg) * 30'(s2_td_reg) + 30'd8192;
        sq_n = 30'(s2_tn_reg) * 30'(s2_tn_reg) + 30'd8192;
        sq_l = 30'(s2_tl_reg) * 30'(s2_tl_reg) + 30'd8192;
        cb_d = 32'(s3_qd_reg) * 32'(s3_kd_reg) + 32'd8192;
        cb_n = 32'(s3_qn_reg) * 32'(s3_kn_reg) + 32'd8192;
        cb_l = 32'(s3_ql_reg) * 32'(s3_kl_reg) + 32'd8192;
        wsum   = (WGT_W + 1)'(s4_wd_reg) + (WGT_W + 1)'(s4_wn_reg);
        fl_sat = (floor_reg > ONE12) ? ONE12 : floor_reg;
        for (int ch = 0; ch < 3; ch++) begin
            zsum[ch] = 30'(s6_pz_reg[0][ch]) + 30'(s6_pz_reg[1][ch])
                     + 30'(s6_pz_reg[2][ch]) + 30'd8192;
            hsum[ch] = 30'(s6_ph_reg[0][ch]) + 30'(s6_ph_reg[1][ch])
                     + 30'(s6_ph_reg[2][ch]) + 30'd8192;
            z_next[ch] = (zsum[ch][29:14] > 16'(COLOR_MAX)) ? COLOR_MAX
                                                            : zsum[ch][25:14];
            h_next[ch] = (hsum[ch][29:14] > 16'(COLOR_MAX)) ? COLOR_MAX
                                                            : hsum[ch][25:14];
        end
        lsum = 30'(s6_pl_reg) + 30'd8192;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_cos_reg <= COS_ROM[item.addr];
            s0_neg_reg <= item.sun_neg;

            s1_sun_reg <= s1_sun_next;
            s1_dd_reg  <= s1_sun_ext - DAY_EDGE;
            s1_dn_reg  <= -DAY_EDGE - s1_sun_ext;
            s1_dl_reg  <= s1_sun_ext + LIGHT_EDGE;

            s2_sun_reg <= s1_sun_reg;
            s2_td_reg  <= ramp_t(s1_dd_reg, RECIP_DAY);
            s2_tn_reg  <= ramp_t(s1_dn_reg, RECIP_DAY);
            s2_tl_reg  <= ramp_t(s1_dl_reg, RECIP_LIGHT);

            s3_sun_reg <= s2_sun_reg;
            s3_qd_reg  <= sq_d[28:14];
            s3_qn_reg  <= sq_n[28:14];
            s3_ql_reg  <= sq_l[28:14];
            s3_kd_reg  <= 16'd49152 - {s2_td_reg, 1'b0};
            s3_kn_reg  <= 16'd49152 - {s2_tn_reg, 1'b0};
            s3_kl_reg  <= 16'd49152 - {s2_tl_reg, 1'b0};

            s4_sun_reg <= s3_sun_reg;
            s4_wd_reg  <= cb_d[29:14];
            s4_wn_reg  <= cb_n[29:14];
            s4_lb_reg  <= cb_l[29:14];

            s5_sun_reg <= s4_sun_reg;
            s5_wd_reg  <= s4_wd_reg;
            s5_wn_reg  <= s4_wn_reg;
            s5_wt_reg  <= (wsum < (WGT_W + 1)'(ONE14)) ? WGT_W'((WGT_W + 1)'(ONE14) - wsum)
                                                       : '0;
            s5_lb_reg  <= s4_lb_reg;
            s5_fl_reg  <= fl_sat;

            s6_sun_reg <= s5_sun_reg;
            for (int ch = 0; ch < 3; ch++) begin
                s6_pz_reg[0][ch] <= 28'(PAL_DAY_Z[ch]) * 28'(s5_wd_reg);
                s6_pz_reg[1][ch] <= 28'(PAL_TW_Z[ch])  * 28'(s5_wt_reg);
                s6_pz_reg[2][ch] <= 28'(PAL_NGT_Z[ch]) * 28'(s5_wn_reg);
                s6_ph_reg[0][ch] <= 28'(PAL_DAY_H[ch]) * 28'(s5_wd_reg);
                s6_ph_reg[1][ch] <= 28'(PAL_TW_H[ch])  * 28'(s5_wt_reg);
                s6_ph_reg[2][ch] <= 28'(PAL_NGT_H[ch]) * 28'(s5_wn_reg);
            end
            s6_pl_reg <= 29'(ONE12 - s5_fl_reg) * 29'(s5_lb_reg);
            s6_fl_reg <= s5_fl_reg;

            s7_sun_reg <= s6_sun_reg;
            for (int ch = 0; ch < 3; ch++) begin
                s7_z_reg[ch] <= z_next[ch];
                s7_h_reg[ch] <= h_next[ch];
            end
            // sum wraps to the field width
            s7_light_reg <= s6_fl_reg + lsum[26:14];
        end
    end

    assign m_sun_height    = s7_sun_reg;
    assign m_zenith_red    = s7_z_reg[0];
    assign m_zenith_green  = s7_z_reg[1];
    assign m_zenith_blue   = s7_z_reg[2];
    assign m_horizon_red   = s7_h_reg[0];
    assign m_horizon_green = s7_h_reg[1];
    assign m_horizon_blue  = s7_h_reg[2];
    assign m_light_level   = s7_light_reg;

endmodule

@@ verif/day_cycle_sky_color_unit_tb.sv @@
// self-checking testbench for the day cycle sky color unit: directed and random phases
module day_cycle_sky_color_unit_tb;
    import dcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LATENCY      = 10;
    localparam int HOLD_CYCLES  = 100;
    localparam int COS_DEPTH    = COS_TABLE_DEPTH;
    localparam int Q14_ONE      = 16384;
    localparam int Q12_ONE      = 4096;
    localparam int DAY_LO       = 819;
    localparam int LIGHT_LO     = 2458;
    localparam longint unsigned RECIP_WEIGHT = 218453;
    localparam longint unsigned RECIP_LIGHT  = 145636;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;

    localparam int unsigned DAY_ZENITH   [3] = '{1434, 2253, 3686};
    localparam int unsigned DAY_HORIZON  [3] = '{2867, 3359, 3891};
    localparam int unsigned TWI_ZENITH   [3] = '{983, 1147, 2130};
    localparam int unsigned TWI_HORIZON  [3] = '{3891, 2130, 983};
    localparam int unsigned NIGHT_ZENITH [3] = '{82, 123, 369};
    localparam int unsigned NIGHT_HORIZON[3] = '{246, 328, 696};

    typedef enum int {RX_STREAM, RX_LIGHT_STALL, RX_HEAVY_STALL} rx_mode_t;

    typedef struct packed {
        logic signed [SUN_W-1:0] sun_height;
        logic [COLOR_W-1:0]      zenith_red;
        logic [COLOR_W-1:0]      zenith_green;
        logic [COLOR_W-1:0]      zenith_blue;
        logic [COLOR_W-1:0]      horizon_red;
        logic [COLOR_W-1:0]      horizon_green;
        logic [COLOR_W-1:0]      horizon_blue;
        logic [LIGHT_W-1:0]      light_level;
    } sky_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [LIGHT_W-1:0]      cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [PHASE_BITS-1:0]   s_day_phase = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [SUN_W-1:0] m_sun_height;
    logic [COLOR_W-1:0]      m_zenith_red;
    logic [COLOR_W-1:0]      m_zenith_green;
    logic [COLOR_W-1:0]      m_zenith_blue;
    logic [COLOR_W-1:0]      m_horizon_red;
    logic [COLOR_W-1:0]      m_horizon_green;
    logic [COLOR_W-1:0]      m_horizon_blue;
    logic [LIGHT_W-1:0]      m_light_level;

    int          quarter_cos [COS_DEPTH + 1];
    int unsigned floor_model = 901;
    sky_result_t pending_sky [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          steady_send = 1'b0;
    int          hold_requests = 0;
    int          hold_started = 0;
    int          hold_left = 0;
    int          seg_left = 0;
    rx_mode_t    rx_mode = RX_STREAM;

    day_cycle_sky_color_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_day_phase     (s_day_phase),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sun_height    (m_sun_height),
        .m_zenith_red    (m_zenith_red),
        .m_zenith_green  (m_zenith_green),
        .m_zenith_blue   (m_zenith_blue),
        .m_horizon_red   (m_horizon_red),
        .m_horizon_green (m_horizon_green),
        .m_horizon_blue  (m_horizon_blue),
        .m_light_level   (m_light_level)
    );

    always #4 aclk = ~aclk;

    // cos(pi/2*i/depth) in Q14 from a Q30 taylor series
    function automatic int quarter_cos_entry(int unsigned i);
        longint unsigned ang, ang_sq, term, plus, minus, diff;
        ang    = (HALF_PI_Q30 * longint'(i)) / longint'(COS_DEPTH);
        ang_sq = (ang * ang) >> 30;
        term   = 64'd1 << 30;
        plus   = term;
        minus  = 0;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * ang_sq) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        diff = (plus > minus) ? plus - minus : 0;
        diff = (diff + 32768) >> 16;
        if (diff > Q14_ONE) begin
            diff = Q14_ONE;
        end
        return int'(diff);
    endfunction

    function automatic longint unsigned smooth_ramp(int ramp_pos, longint unsigned recip);
        longint unsigned t, t_sq;
        if (ramp_pos <= 0) begin
            return 0;
        end
        t = (longint'(ramp_pos) * recip + 32768) >> 16;
        if (t > Q14_ONE) begin
            t = Q14_ONE;
        end
        t_sq = (t * t + 8192) >> 14;
        return (t_sq * (3 * Q14_ONE - 2 * t) + 8192) >> 14;
    endfunction

    function automatic int unsigned blend(int unsigned a, longint unsigned wa,
                                          int unsigned b, longint unsigned wb,
                                          int unsigned c, longint unsigned wc);
        longint unsigned v;
        v = (a * wa + b * wb + c * wc + 8192) >> 14;
        return (v > 4095) ? 4095 : int'(v);
    endfunction

    function automatic sky_result_t sky_for_phase(logic [PHASE_BITS-1:0] phase);
        sky_result_t     r;
        int              slot, cosv, sun;
        longint unsigned w_day, w_night, w_twi, w_light;
        int unsigned     fl;
        slot = int'((longint'(phase[PHASE_BITS-3:0]) * COS_DEPTH) >> (PHASE_BITS - 2));
        case (phase[PHASE_BITS-1 -: 2])
            2'd0: cosv = quarter_cos[slot];
            2'd1: cosv = -quarter_cos[COS_DEPTH - slot];
            2'd2: cosv = -quarter_cos[slot];
            default: cosv = quarter_cos[COS_DEPTH - slot];
        endcase
        sun     = -cosv;
        w_day   = smooth_ramp(sun - DAY_LO, RECIP_WEIGHT);
        w_night = smooth_ramp(-DAY_LO - sun, RECIP_WEIGHT);
        w_twi   = (w_day + w_night < Q14_ONE) ? Q14_ONE - w_day - w_night : 0;
        w_light = smooth_ramp(sun + LIGHT_LO, RECIP_LIGHT);
        r.sun_height    = SUN_W'(sun);
        r.zenith_red    = COLOR_W'(blend(DAY_ZENITH[0], w_day, TWI_ZENITH[0], w_twi,
                                         NIGHT_ZENITH[0], w_night));
        r.zenith_green  = COLOR_W'(blend(DAY_ZENITH[1], w_day, TWI_ZENITH[1], w_twi,
                                         NIGHT_ZENITH[1], w_night));
        r.zenith_blue   = COLOR_W'(blend(DAY_ZENITH[2], w_day, TWI_ZENITH[2], w_twi,
                                         NIGHT_ZENITH[2], w_night));
        r.horizon_red   = COLOR_W'(blend(DAY_HORIZON[0], w_day, TWI_HORIZON[0], w_twi,
                                         NIGHT_HORIZON[0], w_night));
        r.horizon_green = COLOR_W'(blend(DAY_HORIZON[1], w_day, TWI_HORIZON[1], w_twi,
                                         NIGHT_HORIZON[1], w_night));
        r.horizon_blue  = COLOR_W'(blend(DAY_HORIZON[2], w_day, TWI_HORIZON[2], w_twi,
                                         NIGHT_HORIZON[2], w_night));
        // floor saturates at one
        fl = (floor_model > Q12_ONE) ? Q12_ONE : floor_model;
        r.light_level = LIGHT_W'(fl + (((Q12_ONE - fl) * w_light + 8192) >> 14));
        return r;
    endfunction

    // half uniform, half packed around the dawn and dusk bands
    function automatic logic [PHASE_BITS-1:0] rand_phase();
        int unsigned band;
        if ($urandom_range(0, 1) == 0) begin
            return PHASE_BITS'($urandom);
        end
        band = $urandom_range(12000, 21500);
        return ($urandom_range(0, 1) == 0) ? PHASE_BITS'(band) : PHASE_BITS'(65536 - band);
    endfunction

    task automatic send_phase(input logic [PHASE_BITS-1:0] phase);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_send ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_day_phase <= phase;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_sky.push_back(sky_for_phase(phase));
        burst_left--;
    endtask

    // drop valid before the next edge, then wait until every result is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_sky.size() != 0) @(posedge aclk);
    endtask

    task automatic write_floor(input int unsigned value);
        drain_results();
        repeat (LATENCY + 4) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= LIGHT_W'(value);
        @(negedge aclk);
        cfg_we      <= 1'b0;
        floor_model = value;
    endtask

    task automatic test_directed_phases();
        logic [PHASE_BITS-1:0] phases [23] = '{
            16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'h7FFF,
            16'hBFFF, 16'h0001, 16'hAAAA, 16'h5555,
            // sun at -0.35, -0.15, -0.05, 0.05, 0.30, 0.35 in the morning
            16'd12656, 16'd14813, 16'd15862, 16'd16906, 16'd19562, 16'd20112,
            // same heights in the evening
            16'd52880, 16'd50723, 16'd49674, 16'd48630, 16'd45974, 16'd45424};
        foreach (phases[i]) send_phase(phases[i]);
    endtask

    task automatic test_floor_setting(input int unsigned value, input int count);
        write_floor(value);
        repeat (count) send_phase(rand_phase());
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        steady_send = 1'b1;
        repeat (48) send_phase(rand_phase());
        steady_send = 1'b0;
    endtask

    task automatic test_pause_and_resume();
        repeat (12) send_phase(rand_phase());
        drain_results();
        repeat (12) send_phase(rand_phase());
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result side: long hold-offs on request, otherwise random segments of streaming, light stalling or heavy stalling
    always @(negedge aclk) begin
        if (hold_started != hold_requests) begin
            hold_started = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                rx_mode  = rx_mode_t'($urandom_range(0, 2));
                seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            case (rx_mode)
                RX_STREAM:      m_ready <= 1'b1;
                RX_LIGHT_STALL: m_ready <= ($urandom_range(0, 3) != 0);
                default:        m_ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        sky_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sky.size() == 0) begin
                $error("result transfer with no phase pending");
                fail_count++;
            end else begin
                want = pending_sky.pop_front();
                check_field("sun_height", int'(want.sun_height), int'(m_sun_height));
                check_field("zenith_red", want.zenith_red, m_zenith_red);
                check_field("zenith_green", want.zenith_green, m_zenith_green);
                check_field("zenith_blue", want.zenith_blue, m_zenith_blue);
                check_field("horizon_red", want.horizon_red, m_horizon_red);
                check_field("horizon_green", want.horizon_green, m_horizon_green);
                check_field("horizon_blue", want.horizon_blue, m_horizon_blue);
                check_field("light_level", want.light_level, m_light_level);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL day_cycle_sky_color_unit");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i <= COS_DEPTH; i++) quarter_cos[i] = quarter_cos_entry(i);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_phases();
        test_pause_and_resume();
        test_floor_setting(0, 95);
        test_floor_setting(4096, 95);
        test_output_backpressure();
        test_floor_setting(8191, 95);
        test_floor_setting(4097, 95);
        test_floor_setting($urandom_range(1, 4095), 95);
        test_floor_setting($urandom_range(4098, 8190), 95);
        test_floor_setting(901, 70);

        drain_results();
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS day_cycle_sky_color_unit");
        end else begin
            $display("FAIL day_cycle_sky_color_unit");
        end
        $finish;
    end

endmodule
